### rtl/sib_pkg.sv
// Shared types and constants for the snapshot interpolation buffer.
`timescale 1ns / 1ps

package sib_pkg;

	localparam int POS_W   = 32;
	localparam int ID_W    = 32;
	localparam int TIME_W  = 32;
	localparam int WORD_W  = 64;
	localparam int CFG_W   = 24;
	localparam int TGT_W   = 34;
	localparam int ALPHA_W = 16;
	localparam int REM_W   = 33;
	localparam int DIFF_W  = 33;
	localparam int PROD_W  = 50;
	localparam int DIV_CW  = 4;
	localparam int ENTRY_W = 4 * POS_W + 2 * WORD_W;

	localparam logic [1:0] FN_PUSH   = 2'd0;
	localparam logic [1:0] FN_SAMPLE = 2'd1;
	localparam logic [1:0] FN_CLEAR  = 2'd2;

	localparam logic [1:0] ST_ENTITY = 2'd0;
	localparam logic [1:0] ST_NODATA = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;

	localparam logic CFG_DELAY = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(ALPHA_W - 1);
	localparam logic [1:0] AX_LAST = 2'd2;

	typedef struct packed {
		logic       push;
		logic       clr;
		logic       start;
		logic       scan_step;
		logic       div_init;
		logic       div_step;
		logic       rd_sel_b;
		logic       cap_a;
		logic       m_inc;
		logic       cap_b;
		logic       dif;
		logic       mul;
		logic       add;
		logic       ax_inc;
		logic       ld_status;
		logic [1:0] status_code;
		logic       ld_ent_a;
		logic       ld_ent_i;
		logic       j_inc;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic div_last;
		logic have_prev;
		logic have_next;
		logic too_old;
		logic c_zero;
		logic nc_zero;
		logic id_match;
		logic m_last;
		logic ax_last;
		logic j_last;
		logic out_free;
	} stat_t;

endpackage

### rtl/sib_ctrl.sv
// Controller state machine that sequences pushes, clears, slot scans, division and status or entity output.
`timescale 1ns / 1ps

module sib_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      func,
	input  sib_pkg::stat_t  stat,
	output sib_pkg::cmd_t   cmd
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_SCAN  = 12'b000000000010,
		S_DEC   = 12'b000000000100,
		S_EMST  = 12'b000000001000,
		S_DIV   = 12'b000000010000,
		S_RDA   = 12'b000000100000,
		S_CAPA  = 12'b000001000000,
		S_RDB   = 12'b000010000000,
		S_CHKB  = 12'b000100000000,
		S_AXIS  = 12'b001000000000,
		S_EMA   = 12'b010000000000,
		S_EMI   = 12'b100000000000
	} state_t;

	typedef enum logic [2:0] {
		P_DIF = 3'b001,
		P_MUL = 3'b010,
		P_ADD = 3'b100
	} phase_t;

	state_t     state_q, state_n;
	phase_t     phase_q, phase_n;
	logic [1:0] code_q, code_n;
	logic       acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;

	always_comb begin
		state_n = state_q;
		phase_n = phase_q;
		code_n  = code_q;
		cmd     = '0;
		cmd.status_code = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (func)
						sib_pkg::FN_PUSH: cmd.push = 1'b1;
						sib_pkg::FN_CLEAR: cmd.clr = 1'b1;
						sib_pkg::FN_SAMPLE: begin
							cmd.start = 1'b1;
							state_n   = S_SCAN;
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_n = S_DEC;
			end
			S_DEC: begin
				if (!stat.have_prev || (!stat.have_next && stat.too_old)) begin
					code_n  = sib_pkg::ST_NODATA;
					state_n = S_EMST;
				end else if (stat.c_zero) begin
					code_n  = sib_pkg::ST_EMPTY;
					state_n = S_EMST;
				end else if (!stat.have_next) begin
					state_n = S_RDA;
				end else begin
					cmd.div_init = 1'b1;
					state_n      = S_DIV;
				end
			end
			S_EMST: begin
				if (stat.out_free) begin
					cmd.ld_status = 1'b1;
					state_n       = S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_n = S_RDA;
			end
			S_RDA: state_n = S_CAPA;
			S_CAPA: begin
				cmd.cap_a = 1'b1;
				if (!stat.have_next || stat.nc_zero) state_n = S_EMA;
				else state_n = S_RDB;
			end
			S_RDB: begin
				cmd.rd_sel_b = 1'b1;
				state_n      = S_CHKB;
			end
			S_CHKB: begin
				if (stat.id_match) begin
					cmd.cap_b = 1'b1;
					phase_n   = P_DIF;
					state_n   = S_AXIS;
				end else if (stat.m_last) begin
					state_n = S_EMA;
				end else begin
					cmd.m_inc = 1'b1;
					state_n   = S_RDB;
				end
			end
			S_AXIS: begin
				unique case (phase_q)
					P_DIF: begin
						cmd.dif = 1'b1;
						phase_n = P_MUL;
					end
					P_MUL: begin
						cmd.mul = 1'b1;
						phase_n = P_ADD;
					end
					P_ADD: begin
						cmd.add = 1'b1;
						phase_n = P_DIF;
						if (stat.ax_last) state_n = S_EMI;
						else cmd.ax_inc = 1'b1;
					end
					default: phase_n = P_DIF;
				endcase
			end
			S_EMA, S_EMI: begin
				if (stat.out_free) begin
					cmd.ld_ent_a = (state_q == S_EMA);
					cmd.ld_ent_i = (state_q == S_EMI);
					if (stat.j_last) begin
						state_n = S_IDLE;
					end else begin
						cmd.j_inc = 1'b1;
						state_n   = S_RDA;
					end
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= P_DIF;
			code_q  <= sib_pkg::ST_NODATA;
		end else begin
			state_q <= state_n;
			phase_q <= phase_n;
			code_q  <= code_n;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ld_status || cmd.ld_ent_a || cmd.ld_ent_i) |-> stat.out_free)
		else $error("Result loaded while the output register is occupied.");

	a_capb_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap_b |-> stat.id_match)
		else $error("Later entity captured without an id match.");

	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !in_ready)
		else $error("Input accepted while a sample is in progress.");

endmodule

### rtl/sib_dp.sv
// Datapath with snapshot storage, slot scan, alpha divider, interpolation and output register.
`timescale 1ns / 1ps

module sib_dp #(
	parameter int SLOTS        = 8,
	parameter int MAX_ENTITIES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sib_pkg::cmd_t                cmd,
	output sib_pkg::stat_t               stat,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [sib_pkg::CFG_W-1:0]    cfg_data,
	input  logic [31:0]                  time_stamp,
	input  logic [31:0]                  entity_id,
	input  logic signed [31:0]           pos_x,
	input  logic signed [31:0]           pos_y,
	input  logic signed [31:0]           pos_z,
	input  logic [63:0]                  rotation_word,
	input  logic [63:0]                  scale_word,
	input  logic                         last_entity,
	input  logic                         empty_snapshot,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [31:0]                  out_id,
	output logic signed [31:0]           out_x,
	output logic signed [31:0]           out_y,
	output logic signed [31:0]           out_z,
	output logic [63:0]                  out_rotation,
	output logic [63:0]                  out_scale,
	output logic                         final_res
);

	localparam int SW    = $clog2(SLOTS);
	localparam int CW    = $clog2(MAX_ENTITIES + 1);
	localparam int DEPTH = SLOTS * MAX_ENTITIES;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = sib_pkg::POS_W;
	localparam int WW    = sib_pkg::WORD_W;
	localparam int TW    = sib_pkg::TIME_W;
	localparam int GW    = sib_pkg::TGT_W;
	localparam int EW    = sib_pkg::ENTRY_W;
	localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);
	localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_ENTITIES);

	logic [sib_pkg::CFG_W-1:0] delay_q, limit_q;

	logic          valid_q [SLOTS];
	logic [TW-1:0] time_q  [SLOTS];
	logic [CW-1:0] count_q [SLOTS];
	logic [SW-1:0] ws_q;
	logic [CW-1:0] fill_q;

	logic [EW-1:0] mem_q [DEPTH];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          wr_en;
	logic [CW-1:0] fill_inc;
	logic          do_commit;
	logic [CW-1:0] commit_cnt;

	logic signed [GW-1:0] target_q;
	logic [SW-1:0] si_q, prev_q, next_q;
	logic          hp_q, hn_q;
	logic [TW-1:0] prev_t_q, next_t_q;
	logic [CW-1:0] prev_c_q, next_c_q;
	logic signed [GW-1:0] cur_t;
	logic          is_prev_hit, is_next_hit;
	logic [GW-1:0] age;

	logic [sib_pkg::REM_W-1:0]   rem_q;
	logic [TW-1:0]               span;
	logic [sib_pkg::ALPHA_W-1:0] alpha_q;
	logic [sib_pkg::DIV_CW-1:0]  dk_q;
	logic [sib_pkg::REM_W:0]     rem_sh, rem_sub;

	logic [CW-1:0] j_q, m_q;
	logic [1:0]    ax_q;
	logic [31:0]   a_id_q;
	logic [PW-1:0] a_pos_q [3];
	logic [PW-1:0] b_pos_q [3];
	logic [PW-1:0] res_q   [3];
	logic [WW-1:0] a_rot_q, a_sc_q, b_rot_q;
	logic signed [sib_pkg::DIFF_W-1:0] diff_s1;
	logic signed [sib_pkg::PROD_W-1:0] prod_s2;
	logic [31:0]   rd_id;

	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [31:0]   out_id_q;
	logic [PW-1:0] out_x_q, out_y_q, out_z_q;
	logic [WW-1:0] out_rot_q, out_sc_q;
	logic          final_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= sib_pkg::CFG_W'(25600);
			limit_q <= sib_pkg::CFG_W'(64000);
		end else if (cfg_we) begin
			if (cfg_index == sib_pkg::CFG_DELAY) delay_q <= cfg_data;
			if (cfg_index == sib_pkg::CFG_LIMIT) limit_q <= cfg_data;
		end
	end

	// Push bookkeeping.
	assign wr_en      = cmd.push && !empty_snapshot && (fill_q < MAX_CNT);
	assign fill_inc   = wr_en ? fill_q + CW'(1) : fill_q;
	assign do_commit  = cmd.push && (empty_snapshot || last_entity);
	assign commit_cnt = empty_snapshot ? '0 : fill_inc;
	assign wr_addr    = AW'(AW'(ws_q) * AW'(MAX_ENTITIES) + AW'(fill_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) valid_q[i] <= 1'b0;
			ws_q   <= '0;
			fill_q <= '0;
		end else if (cmd.clr) begin
			for (int i = 0; i < SLOTS; i++) valid_q[i] <= 1'b0;
			ws_q   <= '0;
			fill_q <= '0;
		end else if (cmd.push) begin
			if (do_commit) begin
				valid_q[ws_q] <= 1'b1;
				ws_q          <= (ws_q == SLOT_LAST) ? '0 : ws_q + SW'(1);
				fill_q        <= '0;
			end else begin
				if (fill_q == '0) valid_q[ws_q] <= 1'b0;
				fill_q <= fill_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_commit) begin
			time_q[ws_q]  <= time_stamp;
			count_q[ws_q] <= commit_cnt;
		end
	end

	// Entity memory.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {entity_id, pos_x, pos_y, pos_z, rotation_word, scale_word};
		end
	end

	assign rd_addr = cmd.rd_sel_b ? AW'(AW'(next_q) * AW'(MAX_ENTITIES) + AW'(m_q))
	                              : AW'(AW'(prev_q) * AW'(MAX_ENTITIES) + AW'(j_q));

	always_ff @(posedge clk) begin
		rd_q <= mem_q[rd_addr];
	end

	// Slot scan.
	assign cur_t       = GW'({2'b00, time_q[si_q]});
	assign is_prev_hit = valid_q[si_q] && (cur_t <= target_q)
	                     && (!hp_q || time_q[si_q] > prev_t_q);
	assign is_next_hit = valid_q[si_q] && (cur_t > target_q)
	                     && (!hn_q || time_q[si_q] < next_t_q);
	assign age         = GW'(target_q - GW'({2'b00, prev_t_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			si_q <= '0;
			hp_q <= 1'b0;
			hn_q <= 1'b0;
		end else if (cmd.start) begin
			si_q <= '0;
			hp_q <= 1'b0;
			hn_q <= 1'b0;
		end else if (cmd.scan_step) begin
			si_q <= (si_q == SLOT_LAST) ? '0 : si_q + SW'(1);
			if (is_prev_hit) hp_q <= 1'b1;
			if (is_next_hit) hn_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			target_q <= GW'({2'b00, time_stamp}) - GW'({10'b0, delay_q});
		end
		if (cmd.scan_step && is_prev_hit) begin
			prev_q   <= si_q;
			prev_t_q <= time_q[si_q];
			prev_c_q <= count_q[si_q];
		end
		if (cmd.scan_step && is_next_hit) begin
			next_q   <= si_q;
			next_t_q <= time_q[si_q];
			next_c_q <= count_q[si_q];
		end
	end

	// Restoring divider for alpha, one quotient bit per cycle.
	assign span    = next_t_q - prev_t_q;
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_sub = rem_sh - (sib_pkg::REM_W + 1)'(span);

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q   <= age[sib_pkg::REM_W-1:0];
			alpha_q <= '0;
			dk_q    <= '0;
		end else if (cmd.div_step) begin
			if (!rem_sub[sib_pkg::REM_W]) begin
				rem_q   <= rem_sub[sib_pkg::REM_W-1:0];
				alpha_q <= {alpha_q[sib_pkg::ALPHA_W-2:0], 1'b1};
			end else begin
				rem_q   <= rem_sh[sib_pkg::REM_W-1:0];
				alpha_q <= {alpha_q[sib_pkg::ALPHA_W-2:0], 1'b0};
			end
			dk_q <= dk_q + sib_pkg::DIV_CW'(1);
		end
	end

	// Entity walk and interpolation.
	assign rd_id = rd_q[EW-1 -: 32];

	always_ff @(posedge clk) begin
		if (cmd.start) j_q <= '0;
		else if (cmd.j_inc) j_q <= j_q + CW'(1);
		if (cmd.cap_a) m_q <= '0;
		else if (cmd.m_inc) m_q <= m_q + CW'(1);
		if (cmd.cap_b) ax_q <= '0;
		else if (cmd.ax_inc) ax_q <= ax_q + 2'd1;
		if (cmd.cap_a) begin
			a_id_q     <= rd_id;
			a_pos_q[0] <= rd_q[4*PW+2*WW-1-PW -: PW];
			a_pos_q[1] <= rd_q[4*PW+2*WW-1-2*PW -: PW];
			a_pos_q[2] <= rd_q[4*PW+2*WW-1-3*PW -: PW];
			a_rot_q    <= rd_q[2*WW-1 -: WW];
			a_sc_q     <= rd_q[WW-1:0];
		end
		if (cmd.cap_b) begin
			b_pos_q[0] <= rd_q[4*PW+2*WW-1-PW -: PW];
			b_pos_q[1] <= rd_q[4*PW+2*WW-1-2*PW -: PW];
			b_pos_q[2] <= rd_q[4*PW+2*WW-1-3*PW -: PW];
			b_rot_q    <= rd_q[2*WW-1 -: WW];
		end
		if (cmd.dif) begin
			diff_s1 <= sib_pkg::DIFF_W'($signed(b_pos_q[ax_q]))
			         - sib_pkg::DIFF_W'($signed(a_pos_q[ax_q]));
		end
		if (cmd.mul) begin
			prod_s2 <= sib_pkg::PROD_W'(diff_s1)
			         * sib_pkg::PROD_W'($signed({1'b0, alpha_q}));
		end
		if (cmd.add) begin
			res_q[ax_q] <= a_pos_q[ax_q] + prod_s2[PW+sib_pkg::ALPHA_W-1:sib_pkg::ALPHA_W];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_status || cmd.ld_ent_a || cmd.ld_ent_i) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_status) begin
			status_q  <= cmd.status_code;
			out_id_q  <= '0;
			out_x_q   <= '0;
			out_y_q   <= '0;
			out_z_q   <= '0;
			out_rot_q <= '0;
			out_sc_q  <= '0;
			final_q   <= 1'b1;
		end else if (cmd.ld_ent_a || cmd.ld_ent_i) begin
			status_q  <= sib_pkg::ST_ENTITY;
			out_id_q  <= a_id_q;
			out_x_q   <= cmd.ld_ent_i ? res_q[0] : a_pos_q[0];
			out_y_q   <= cmd.ld_ent_i ? res_q[1] : a_pos_q[1];
			out_z_q   <= cmd.ld_ent_i ? res_q[2] : a_pos_q[2];
			out_rot_q <= (cmd.ld_ent_i && alpha_q[sib_pkg::ALPHA_W-1]) ? b_rot_q : a_rot_q;
			out_sc_q  <= a_sc_q;
			final_q   <= stat.j_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_id       = out_id_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign out_z        = out_z_q;
	assign out_rotation = out_rot_q;
	assign out_scale    = out_sc_q;
	assign final_res    = final_q;

	assign stat.scan_last = (si_q == SLOT_LAST);
	assign stat.div_last  = (dk_q == sib_pkg::DIV_LAST);
	assign stat.have_prev = hp_q;
	assign stat.have_next = hn_q;
	assign stat.too_old   = (age > GW'({10'b0, limit_q}));
	assign stat.c_zero    = (prev_c_q == '0);
	assign stat.nc_zero   = (next_c_q == '0);
	assign stat.id_match  = (rd_id == a_id_q);
	assign stat.m_last    = (m_q + CW'(1) == next_c_q);
	assign stat.ax_last   = (ax_q == sib_pkg::AX_LAST);
	assign stat.j_last    = (j_q + CW'(1) == prev_c_q);
	assign stat.out_free  = !out_valid_q || out_ready;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MAX_CNT)
		else $error("Fill count exceeds the entity capacity.");

	a_jinc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.j_inc |-> (j_q + CW'(1) < prev_c_q))
		else $error("Entity index stepped past the snapshot count.");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		do_commit |=> valid_q[$past(ws_q)])
		else $error("Committed slot is not marked valid.");

endmodule

### rtl/snapshot_interpolation_buffer.sv
// Top level of the snapshot interpolation buffer.
`timescale 1ns / 1ps

// Channel  Handshake             Word
// in       in_valid / in_ready   func, time_stamp, entity_id, pos_x/y/z, rotation, scale, flags
// out      out_valid / out_ready status, out_id, out_x/y/z, out_rotation, out_scale, final_res
// cfg      cfg_we                cfg_index, cfg_data
//
// A push or clear completes in the idle state. A sample runs a scan over all SLOTS slots and a
// decision step, then the alpha divider when two snapshots bracket the target, and per entity a
// read of it, an id compare per entry of the later snapshot, the difference, shared multiply and
// add steps for each of the three axes and a load of the result; a status result is just loaded.
// The single read port of the entity memory sets the pace of the walk.
// Reset clears slot valid bits, the write slot and fill count, with no clearing pass.
// A stalled output holds the current result and stalls the sample; the next input is taken once the sample ends.

module snapshot_interpolation_buffer #(
	parameter int SLOTS        = 8,
	parameter int MAX_ENTITIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [31:0]        time_stamp,
	input  logic [31:0]        entity_id,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [63:0]        rotation_word,
	input  logic [63:0]        scale_word,
	input  logic               last_entity,
	input  logic               empty_snapshot,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [23:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [31:0]        out_id,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [63:0]        out_rotation,
	output logic [63:0]        out_scale,
	output logic               final_res
);

	sib_pkg::cmd_t  cmd;
	sib_pkg::stat_t stat;

	sib_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.stat     (stat),
		.cmd      (cmd)
	);

	sib_dp #(
		.SLOTS        (SLOTS),
		.MAX_ENTITIES (MAX_ENTITIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.time_stamp     (time_stamp),
		.entity_id      (entity_id),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.rotation_word  (rotation_word),
		.scale_word     (scale_word),
		.last_entity    (last_entity),
		.empty_snapshot (empty_snapshot),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.out_id         (out_id),
		.out_x          (out_x),
		.out_y          (out_y),
		.out_z          (out_z),
		.out_rotation   (out_rotation),
		.out_scale      (out_scale),
		.final_res      (final_res)
	);

endmodule
